// ===== sv/kwsc_pkg.sv =====
// kwsc_pkg: shared types and constants of the keyword substitution cipher unit
// used by the channel interfaces and all kwsc modules, no dependencies
`default_nettype none

package kwsc_pkg;

    localparam int LETTER_W   = 5;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_TEXT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_CASE  = 1'b1;

    localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] ASCII_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] ASCII_LOWER_Z = 8'h7A;

    typedef struct packed {
        logic                cmd;
        logic                letter_ok;
        logic [LETTER_W-1:0] letter_idx;
        logic [BYTE_W-1:0]   data_byte;
        logic                last;
    } kw_item_t;

    typedef struct packed {
        logic decode_mode;
        logic upper_case_output;
    } kw_cfg_t;

endpackage

`default_nettype wire

// ===== sv/kwsc_if.sv =====
// kwsc_item_if and kwsc_result_if: valid/ready channels of the cipher unit
// depends on kwsc_pkg for field widths
`default_nettype none

interface kwsc_item_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [kwsc_pkg::BYTE_W-1:0] data_byte;
    logic                        last;

    modport source (output valid, output cmd, output data_byte, output last, input ready);
    modport sink   (input valid, input cmd, input data_byte, input last, output ready);
endinterface

interface kwsc_result_if;
    logic                        valid;
    logic                        ready;
    logic [kwsc_pkg::BYTE_W-1:0] out_byte;
    logic                        out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// ===== sv/kwsc_front.sv =====
// kwsc_front: accepts input transfers and classifies each byte as letter or not
// depends on kwsc_pkg and kwsc_item_if, feeds kwsc_queue
`default_nettype none

module kwsc_front #(
    parameter int ALPHABET_SIZE = 26
) (
    kwsc_item_if.sink            item,
    input  wire logic            q_full,
    output logic                 push,
    output kwsc_pkg::kw_item_t   push_item
);

    logic [kwsc_pkg::BYTE_W-1:0] offset;
    logic                        is_upper;
    logic                        is_lower;

    always_comb
    begin
        is_upper = (item.data_byte >= kwsc_pkg::ASCII_UPPER_A) &&
                   (item.data_byte <= kwsc_pkg::ASCII_UPPER_Z);
        is_lower = (item.data_byte >= kwsc_pkg::ASCII_LOWER_A) &&
                   (item.data_byte <= kwsc_pkg::ASCII_LOWER_Z);
        offset   = is_upper ? (item.data_byte - kwsc_pkg::ASCII_UPPER_A)
                            : (item.data_byte - kwsc_pkg::ASCII_LOWER_A);

        push_item.cmd        = item.cmd;
        push_item.letter_idx = offset[kwsc_pkg::LETTER_W-1:0];
        push_item.letter_ok  = (is_upper || is_lower) &&
                               (offset < kwsc_pkg::BYTE_W'(ALPHABET_SIZE));
        push_item.data_byte  = item.data_byte;
        push_item.last       = item.last;
    end

    assign item.ready = !q_full;
    assign push       = item.valid && !q_full;

endmodule

`default_nettype wire

// ===== sv/kwsc_queue.sv =====
// kwsc_queue: two-entry queue of classified items between front and back
// depends on kwsc_pkg
`default_nettype none

module kwsc_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire kwsc_pkg::kw_item_t push_item,
    output logic                    full,
    input  wire logic               pop,
    output logic                    head_valid,
    output kwsc_pkg::kw_item_t      head_item
);

    kwsc_pkg::kw_item_t mem [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/kwsc_back.sv =====
// kwsc_back: alphabet tables, keyword build and fill walk, text translation
// depends on kwsc_pkg and kwsc_result_if, reads from kwsc_queue
`default_nettype none

module kwsc_back #(
    parameter int ALPHABET_SIZE = 26
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire kwsc_pkg::kw_cfg_t  cfg,
    input  wire logic               head_valid,
    input  wire kwsc_pkg::kw_item_t head_item,
    output logic                    pop,
    kwsc_result_if.source           result
);

    localparam int IDX_W = $clog2(ALPHABET_SIZE);
    localparam int POS_W = $clog2(ALPHABET_SIZE + 1);

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_FILL = 1'b1;

    logic [IDX_W-1:0]         fwd_reg [ALPHABET_SIZE];
    logic [IDX_W-1:0]         inv_reg [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] used_reg, used_next, used_eff;
    logic [POS_W-1:0]         pos_reg, pos_next, pos_eff;
    logic                     building_reg, building_next;
    logic                     state_reg, state_next;
    logic [IDX_W-1:0]         fill_reg, fill_next;

    logic                        out_valid_reg, out_valid_next;
    logic [kwsc_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                        out_last_reg, out_last_next;

    logic                        place_en;
    logic [IDX_W-1:0]            place_letter;
    logic [IDX_W-1:0]            place_pos;
    logic [IDX_W-1:0]            head_idx;
    logic [IDX_W-1:0]            mapped;
    logic [kwsc_pkg::BYTE_W-1:0] case_base;

    assign head_idx = head_item.letter_idx[IDX_W-1:0];
    assign pop      = head_valid && (state_reg == ST_RUN) &&
                      ((head_item.cmd == kwsc_pkg::CMD_KEY) ||
                       !out_valid_reg || result.ready);

    always_comb
    begin
        used_eff      = building_reg ? used_reg : '0;
        pos_eff       = building_reg ? pos_reg : '0;
        used_next     = used_reg;
        pos_next      = pos_reg;
        building_next = building_reg;
        state_next    = state_reg;
        fill_next     = fill_reg;
        place_en      = 1'b0;
        place_letter  = head_idx;
        place_pos     = pos_eff[IDX_W-1:0];

        mapped    = cfg.decode_mode ? inv_reg[head_idx] : fwd_reg[head_idx];
        case_base = cfg.upper_case_output ? kwsc_pkg::ASCII_UPPER_A
                                          : kwsc_pkg::ASCII_LOWER_A;

        out_valid_next = out_valid_reg && !result.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_RUN:
            begin
                if (pop && (head_item.cmd == kwsc_pkg::CMD_KEY))
                begin
                    place_en = head_item.letter_ok && !used_eff[head_idx] &&
                               (pos_eff < POS_W'(ALPHABET_SIZE));
                    used_next     = used_eff;
                    pos_next      = pos_eff;
                    building_next = 1'b1;
                    if (place_en)
                    begin
                        used_next = used_eff | (ALPHABET_SIZE'(1) << head_idx);
                        pos_next  = pos_eff + POS_W'(1);
                    end
                    if (head_item.last)
                    begin
                        state_next = ST_FILL;
                        fill_next  = '0;
                    end
                end
                else if (pop)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = head_item.last;
                    out_byte_next  = head_item.letter_ok
                                   ? (case_base + kwsc_pkg::BYTE_W'(mapped))
                                   : head_item.data_byte;
                end
            end
            ST_FILL:
            begin
                place_letter = fill_reg;
                place_pos    = pos_reg[IDX_W-1:0];
                place_en     = !used_reg[fill_reg] &&
                               (pos_reg < POS_W'(ALPHABET_SIZE));
                if (place_en)
                begin
                    used_next = used_reg | (ALPHABET_SIZE'(1) << fill_reg);
                    pos_next  = pos_reg + POS_W'(1);
                end
                fill_next = fill_reg + IDX_W'(1);
                if (fill_reg == IDX_W'(ALPHABET_SIZE - 1))
                begin
                    pos_next      = POS_W'(ALPHABET_SIZE);
                    building_next = 1'b0;
                    state_next    = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                fwd_reg[i] <= IDX_W'(i);
                inv_reg[i] <= IDX_W'(i);
            end
            used_reg      <= '0;
            pos_reg       <= '0;
            building_reg  <= 1'b0;
            state_reg     <= ST_RUN;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (place_en)
            begin
                fwd_reg[place_pos]    <= place_letter;
                inv_reg[place_letter] <= place_pos;
            end
            used_reg      <= used_next;
            pos_reg       <= pos_next;
            building_reg  <= building_next;
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.out_last = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/keyword_substitution_cipher_unit.sv =====
// keyword_substitution_cipher_unit: top level of the keyword substitution cipher
// depends on kwsc_pkg, kwsc_if, kwsc_front, kwsc_queue and kwsc_back
//
// item channel carries keyword bytes (cmd key) and text bytes (cmd text);
// result channel gives one transfer per text byte, none per keyword byte.
// keyword letters build the cipher alphabet in arrival order, the keyword byte
// flagged last starts a walk over all ALPHABET_SIZE letters that places the
// unused ones, one letter per cycle.
// a text byte is translated by one table lookup: it passes the queue entry and
// then the lookup register before its result transfer, and text bytes stream
// at one per cycle while the receiver is ready and no fill walk runs.
// a two-entry queue sits between the classifying front and the table back, so
// the item channel keeps taking bytes until the queue fills when the receiver
// stalls or a fill walk runs; the finished result waits in its output register.
// reset sets both tables to identity, clears keyword state, decode_mode and
// upper_case_output; cfg writes (index 0 decode_mode, index 1 upper_case_output)
// belong in idle periods only.
`default_nettype none

module keyword_substitution_cipher_unit #(
    parameter int ALPHABET_SIZE = 26
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    kwsc_item_if.sink                            item,
    kwsc_result_if.source                        result,
    input  wire logic                            cfg_we,
    input  wire logic [kwsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [kwsc_pkg::CFG_DATA_W-1:0] cfg_data
);

    kwsc_pkg::kw_cfg_t  cfg_reg;
    kwsc_pkg::kw_item_t push_item;
    kwsc_pkg::kw_item_t head_item;
    logic               push;
    logic               q_full;
    logic               pop;
    logic               head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == kwsc_pkg::REG_DECODE_MODE)
            begin
                cfg_reg.decode_mode <= cfg_data[0];
            end
            if (cfg_index == kwsc_pkg::REG_UPPER_CASE)
            begin
                cfg_reg.upper_case_output <= cfg_data[0];
            end
        end
    end

    kwsc_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .item      (item),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    kwsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    kwsc_back #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .result     (result)
    );

endmodule

`default_nettype wire

// ===== test/keyword_substitution_cipher_unit_test.sv =====
// keyword_substitution_cipher_unit_test: self-checking bench for the keyword substitution cipher
// keyword and text transfers are predicted in-bench and compared against the result channel
// depends on kwsc_pkg, kwsc_item_if, kwsc_result_if and keyword_substitution_cipher_unit

module keyword_substitution_cipher_unit_test;
    import kwsc_pkg::*;

    localparam int ALPHA_SIZE  = 26;
    localparam int FILL_CYCLES = 40;
    localparam int QUIET_LIMIT = 3000;
    localparam int ITEM_TARGET = 1250;

    typedef struct packed {
        logic              cmd;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } cipher_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
    } cipher_out_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kwsc_item_if   item_if();
    kwsc_result_if result_if();

    keyword_substitution_cipher_unit #(
        .ALPHABET_SIZE(ALPHA_SIZE)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_if),
        .result   (result_if),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // expected cipher state
    logic [LETTER_W-1:0]   fwd_map [26];
    logic [LETTER_W-1:0]   inv_map [26];
    logic [25:0]           letter_used;
    logic [LETTER_W-1:0]   next_pos;
    logic                  keying;
    logic                  decode_on;
    logic                  upper_on;

    cipher_in_t  send_q[$];
    cipher_out_t cipher_expected[$];

    int  queued_count   = 0;
    int  accepted_count = 0;
    int  quiet_cycles   = 0;
    int  error_count    = 0;
    int  send_gap;
    int  recv_gap;
    bit  send_idle;
    bit  recv_idle;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit letter_of(input logic [BYTE_W-1:0] b, output logic [LETTER_W-1:0] idx);
        bit ok;
        ok  = 1'b0;
        idx = '0;
        if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z)
        begin
            ok  = 1'b1;
            idx = LETTER_W'(b - ASCII_UPPER_A);
        end
        else if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z)
        begin
            ok  = 1'b1;
            idx = LETTER_W'(b - ASCII_LOWER_A);
        end
        if (idx >= ALPHA_SIZE)
            ok = 1'b0;
        return ok;
    endfunction

    function automatic void place_letter(input logic [LETTER_W-1:0] letter);
        if (next_pos < ALPHA_SIZE)
        begin
            fwd_map[next_pos] = letter;
            inv_map[letter]   = next_pos;
            letter_used[letter] = 1'b1;
            next_pos = next_pos + LETTER_W'(1);
        end
    endfunction

    function automatic void apply_cipher_item(input cipher_in_t it);
        logic [LETTER_W-1:0] idx;
        logic [LETTER_W-1:0] m;
        bit                  ok;
        cipher_out_t         res;
        int                  l;
        ok = letter_of(it.data_byte, idx);
        if (it.cmd == CMD_KEY)
        begin
            if (!keying)
            begin
                letter_used = '0;
                next_pos    = '0;
                keying      = 1'b1;
            end
            if (ok && !letter_used[idx])
                place_letter(idx);
            if (it.last)
            begin
                for (l = 0; l < ALPHA_SIZE; l++)
                    if (!letter_used[l])
                        place_letter(LETTER_W'(l));
                next_pos = LETTER_W'(ALPHA_SIZE);
                keying   = 1'b0;
            end
        end
        else
        begin
            res.out_byte = it.data_byte;
            if (ok)
            begin
                m = decode_on ? inv_map[idx] : fwd_map[idx];
                if (m > 25)
                    m = 25;
                res.out_byte = (upper_on ? ASCII_UPPER_A : ASCII_LOWER_A) + BYTE_W'(m);
            end
            res.out_last = it.last;
            cipher_expected.push_back(res);
        end
    endfunction

    function automatic int idle_cycles(input bit on);
        int r;
        if (!on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_letter();
        logic [BYTE_W-1:0] idx;
        idx = BYTE_W'($urandom_range(0, ALPHA_SIZE - 1));
        return ($urandom_range(0, 1) ? ASCII_UPPER_A : ASCII_LOWER_A) + idx;
    endfunction

    function automatic void push_item(input logic cmd, input logic [BYTE_W-1:0] b,
                                      input logic lst);
        cipher_in_t it;
        it.cmd       = cmd;
        it.data_byte = b;
        it.last      = lst;
        send_q.push_back(it);
        queued_count++;
    endfunction

    // mostly letters, some noise, now and then text mixed in or no closing byte
    function automatic void push_keyword();
        int                len;
        int                k;
        bit                closed;
        logic [BYTE_W-1:0] b;
        len    = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 45) : $urandom_range(0, 10);
        closed = ($urandom_range(0, 9) != 0);
        for (k = 0; k <= len; k++)
        begin
            if ($urandom_range(0, 99) < 82)
                b = rand_letter();
            else
                b = BYTE_W'($urandom_range(0, 255));
            if (k > 0 && $urandom_range(0, 99) < 5)
                push_item(CMD_TEXT, rand_letter(), 1'($urandom_range(0, 1)));
            push_item(CMD_KEY, b, closed && k == len);
        end
    endfunction

    function automatic void push_text_run();
        int                len;
        int                k;
        logic [BYTE_W-1:0] b;
        logic              lst;
        len = $urandom_range(1, 20);
        for (k = 1; k <= len; k++)
        begin
            if ($urandom_range(0, 9) < 7)
                b = rand_letter();
            else
                b = BYTE_W'($urandom_range(0, 255));
            lst = (k == len) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 19) == 0);
            push_item(CMD_TEXT, b, lst);
        end
    endfunction

    task automatic wait_drained();
        while (accepted_count != queued_count || cipher_expected.size() != 0)
            @(posedge clk);
        repeat (FILL_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_DECODE_MODE)
            decode_on = val;
        else
            upper_on = val;
    endtask

    // item driver
    always @(posedge clk)
    begin
        cipher_in_t nxt;
        if (!rst_n)
        begin
            item_if.valid <= 1'b0;
            send_gap      <= 0;
        end
        else if (!item_if.valid || item_if.ready)
        begin
            if (send_gap != 0 || send_q.size() == 0)
            begin
                item_if.valid <= 1'b0;
                if (send_gap != 0)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                nxt = send_q.pop_front();
                item_if.valid     <= 1'b1;
                item_if.cmd       <= nxt.cmd;
                item_if.data_byte <= nxt.data_byte;
                item_if.last      <= nxt.last;
                send_gap          <= idle_cycles(send_idle);
            end
        end
    end

    // result receiver
    always @(posedge clk)
    begin
        int g;
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            recv_gap        <= 0;
        end
        else if (recv_gap != 0)
        begin
            result_if.ready <= 1'b0;
            recv_gap        <= recv_gap - 1;
        end
        else
        begin
            g = idle_cycles(recv_idle);
            result_if.ready <= (g == 0);
            recv_gap        <= (g == 0) ? 0 : g - 1;
        end
    end

    // transfer monitor and checker
    always @(posedge clk)
    begin
        cipher_in_t  seen;
        cipher_out_t want;
        bit          moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (item_if.valid && item_if.ready)
            begin
                seen.cmd       = item_if.cmd;
                seen.data_byte = item_if.data_byte;
                seen.last      = item_if.last;
                apply_cipher_item(seen);
                accepted_count++;
                moved = 1'b1;
            end
            if (result_if.valid && result_if.ready)
            begin
                moved = 1'b1;
                if (cipher_expected.size() == 0)
                begin
                    $error("unexpected result transfer: out_byte %02h out_last %0b",
                           result_if.out_byte, result_if.out_last);
                    error_count++;
                end
                else
                begin
                    want = cipher_expected.pop_front();
                    if (result_if.out_byte !== want.out_byte)
                    begin
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               want.out_byte, result_if.out_byte);
                        error_count++;
                    end
                    if (result_if.out_last !== want.out_last)
                    begin
                        $error("out_last mismatch: expected %0b, actual %0b",
                               want.out_last, result_if.out_last);
                        error_count++;
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int   phase;
        int   target;
        logic dm;
        logic uc;
        rst_n             = 1'b0;
        item_if.valid     = 1'b0;
        item_if.cmd       = CMD_KEY;
        item_if.data_byte = '0;
        item_if.last      = 1'b0;
        result_if.ready   = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_DECODE_MODE;
        cfg_data          = '0;
        for (int i = 0; i < 26; i++)
        begin
            fwd_map[i] = LETTER_W'(i);
            inv_map[i] = LETTER_W'(i);
        end
        letter_used = '0;
        next_pos    = '0;
        keying      = 1'b0;
        decode_on   = 1'b0;
        upper_on    = 1'b0;
        send_idle   = 1'b1;
        recv_idle   = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // identity tables, letter bounds and non-letters
        push_item(CMD_TEXT, "A", 1'b0);
        push_item(CMD_TEXT, "z", 1'b0);
        push_item(CMD_TEXT, 8'h00, 1'b0);
        push_item(CMD_TEXT, 8'hFF, 1'b0);
        push_item(CMD_TEXT, 8'h40, 1'b0);
        push_item(CMD_TEXT, 8'h5B, 1'b0);
        push_item(CMD_TEXT, 8'h60, 1'b0);
        push_item(CMD_TEXT, 8'h7B, 1'b1);
        // keyword with a non-letter, text during a partial keyword, repeat letter
        push_item(CMD_KEY, "Z", 1'b0);
        push_item(CMD_KEY, "e", 1'b0);
        push_item(CMD_KEY, "1", 1'b0);
        push_item(CMD_KEY, "b", 1'b0);
        push_item(CMD_KEY, "R", 1'b0);
        push_item(CMD_KEY, "A", 1'b0);
        push_item(CMD_TEXT, "b", 1'b0);
        push_item(CMD_KEY, "z", 1'b0);
        push_item(CMD_KEY, "!", 1'b1);
        push_item(CMD_TEXT, "a", 1'b0);
        push_item(CMD_TEXT, "Y", 1'b1);
        wait_drained();
        write_cfg(REG_DECODE_MODE, 1'b1);
        write_cfg(REG_UPPER_CASE, 1'b1);
        push_item(CMD_TEXT, "z", 1'b0);
        push_item(CMD_TEXT, "M", 1'b1);
        wait_drained();
        // keyword of a single non-letter closes to the plain alphabet
        write_cfg(REG_DECODE_MODE, 1'b0);
        push_item(CMD_KEY, 8'hC1, 1'b1);
        push_item(CMD_TEXT, "q", 1'b1);

        phase = 0;
        while (queued_count < ITEM_TARGET)
        begin
            wait_drained();
            if (phase < 4)
            begin
                dm = phase[0];
                uc = phase[1];
            end
            else
            begin
                dm = 1'($urandom_range(0, 1));
                uc = 1'($urandom_range(0, 1));
            end
            write_cfg(REG_DECODE_MODE, dm);
            write_cfg(REG_UPPER_CASE, uc);
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            target = queued_count + $urandom_range(60, 140);
            while (queued_count < target)
            begin
                if ($urandom_range(0, 9) < 4)
                    push_keyword();
                else
                    push_text_run();
            end
            phase++;
        end
        wait_drained();

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/kwsc_pkg.sv
sv/kwsc_if.sv
sv/kwsc_front.sv
sv/kwsc_queue.sv
sv/kwsc_back.sv
sv/keyword_substitution_cipher_unit.sv
test/keyword_substitution_cipher_unit_test.sv
